// File: design/tpws_pkg.sv
package tpws_pkg;

    localparam int PATCH_SUM_W = 16;
    localparam int TIME_SUM_W  = 18;
    localparam int PIDX_W      = 7;
    localparam int CIDX_W      = 7;
    localparam int CELL_W      = 10;  // signed cell number, covers mirrored seeds
    localparam int ROW_W       = 5;
    localparam int EDGE_W      = 3;
    localparam int WR_INDEX_W  = 2;
    localparam int WR_DATA_W   = 3;

    localparam int MIRROR_BASE   = 95;
    localparam int FULL_PER_ROW  = 7;
    localparam int THIRD_PER_ROW = 23;
    localparam int FULL_STRIDE   = 8;
    localparam int THIRD_STRIDE  = 24;
    localparam int MAX_EDGE      = 4;
    localparam int FULL_COUNT    = 77;
    localparam int THIRD_COUNT   = 69;

    localparam logic [PATCH_SUM_W-1:0] PATCH_SUM_MAX = '1;
    localparam logic [TIME_SUM_W-1:0]  TIME_SUM_MAX  = '1;
    localparam logic [EDGE_W-1:0]      EDGE_RESET    = 3'd2;

    typedef enum logic
    {
        CMD_STORE = 1'b0,
        CMD_EVAL  = 1'b1
    } cmd_t;

    typedef enum logic [WR_INDEX_W-1:0]
    {
        REG_SIDE_SELECT = 2'd0,
        REG_MODULE_SIZE = 2'd1,
        REG_PATCH_EDGE  = 2'd2
    } reg_index_t;

    // patch / per_row by reciprocal multiply; estimate is high by at most one
    function automatic logic [ROW_W-1:0] row_of(input logic [PIDX_W-1:0] p,
                                                input logic third);
        logic [12:0]      prod;
        logic [ROW_W-1:0] q;
        logic [8:0]       back;
        if (third)
        begin
            prod = 13'(p) * 13'd45;
            q    = ROW_W'(prod >> 10);
            back = 9'(q) * 9'(THIRD_PER_ROW);
        end
        else
        begin
            prod = 13'(p) * 13'd37;
            q    = ROW_W'(prod >> 8);
            back = 9'(q) * 9'(FULL_PER_ROW);
        end
        if (back > 9'(p))
        begin
            q = q - ROW_W'(1);
        end
        return q;
    endfunction

    function automatic logic signed [CELL_W-1:0] seed_of(input logic [PIDX_W-1:0] p,
                                                         input logic third,
                                                         input logic side);
        logic [8:0] up;
        up = 9'(p) + 9'(row_of(p, third));
        if (side)
        begin
            return CELL_W'(MIRROR_BASE) - CELL_W'(up);
        end
        return CELL_W'(up);
    endfunction

endpackage

// File: design/tpws_ram.sv
module tpws_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: design/trigger_patch_window_sum_unit.sv
// Store word: written in the accepting cycle, no result, busy stays low.
// Evaluate word out of range: status result strobed in the next cycle.
// Evaluate word: SEED, CELLS over E*E cells with one channel read a cycle, CDRAIN, META,
// then HREAD per stored sum and HDRAIN if any are stored, FINISH strobes done; E = clamped edge.
// Next word may be accepted in the done cycle; receiver cannot stall done.
// Reset returns settings to defaults (patch edge 2), clears channel and history valid bits; memories are not swept.
module trigger_patch_window_sum_unit
    import tpws_pkg::*;
#(
    parameter int NUM_CHANNELS = 96,
    parameter int NUM_PATCHES  = 77,
    parameter int WINDOW_DEPTH = 4,
    parameter int ADC_BITS     = 12
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    command,
    input  logic [CIDX_W-1:0]       channel_index,
    input  logic [ADC_BITS-1:0]     adc_value,
    input  logic [PIDX_W-1:0]       patch_index,
    input  logic                    write_enable,
    input  logic [WR_INDEX_W-1:0]   write_index,
    input  logic [WR_DATA_W-1:0]    write_data,
    output logic                    done,
    output logic [PATCH_SUM_W-1:0]  patch_sum,
    output logic [TIME_SUM_W-1:0]   time_sum,
    output logic [PATCH_SUM_W-1:0]  evicted_sum,
    output logic                    evicted_valid,
    output logic                    status
);

    localparam int CH_AW      = $clog2(NUM_CHANNELS);
    localparam int PATCH_AW   = (NUM_PATCHES > 1) ? $clog2(NUM_PATCHES) : 1;
    localparam int HIST_DEPTH = NUM_PATCHES * WINDOW_DEPTH;
    localparam int HIST_AW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int SLOT_W     = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W      = $clog2(WINDOW_DEPTH + 1);
    localparam int META_W     = CNT_W + SLOT_W;
    localparam int HB_W       = PIDX_W + SLOT_W + 1;
    localparam int PACC_W     = (ADC_BITS + 4 > 17) ? ADC_BITS + 4 : 17;
    localparam int TACC_W     = (PATCH_SUM_W + CNT_W > 19) ? PATCH_SUM_W + CNT_W : 19;

    typedef enum logic [2:0]
    {
        IDLE,
        SEED,
        CELLS,
        CDRAIN,
        META,
        HREAD,
        HDRAIN,
        FINISH
    } state_t;

    state_t state_reg;

    logic                      side_select_reg;
    logic                      module_size_reg;
    logic [EDGE_W-1:0]         patch_edge_reg;

    logic [PIDX_W-1:0]         patch_reg;
    logic [EDGE_W-1:0]         edge_reg;
    logic [1:0]                k_reg;
    logic [1:0]                l_reg;
    logic signed [CELL_W-1:0]  cell_reg;
    logic signed [CELL_W-1:0]  row_reg;
    logic                      rd_ok_reg;
    logic [PACC_W-1:0]         pacc_reg;
    logic [PATCH_SUM_W-1:0]    psum_reg;

    logic [HIST_AW-1:0]        hist_base_reg;
    logic [CNT_W-1:0]          n_reg;
    logic [SLOT_W-1:0]         head_reg;
    logic                      full_reg;
    logic [CNT_W-1:0]          i_reg;
    logic [SLOT_W-1:0]         slot_reg;
    logic                      hv_reg;
    logic                      hfirst_reg;
    logic [TACC_W-1:0]         tacc_reg;
    logic [PATCH_SUM_W-1:0]    evicted_reg;

    logic                      ch_valid_reg [NUM_CHANNELS];
    logic                      meta_valid_reg [NUM_PATCHES];

    logic                      done_reg;
    logic                      status_reg;
    logic [PATCH_SUM_W-1:0]    patch_sum_reg;
    logic [TIME_SUM_W-1:0]     time_sum_reg;
    logic [PATCH_SUM_W-1:0]    evicted_sum_reg;
    logic                      evicted_valid_reg;

    logic                      accept;
    logic                      store_ok;
    logic                      eval_ok;
    logic [CH_AW-1:0]          store_addr;
    logic [8:0]                count_lim;
    logic                      k_last;
    logic                      l_last;
    logic signed [CELL_W-1:0]  step_base;
    logic signed [CELL_W-1:0]  step_delta;
    logic signed [CELL_W-1:0]  step_next;
    logic                      cell_in_grid;
    logic [CH_AW-1:0]          cell_addr;
    logic [PATCH_AW-1:0]       patch_addr;
    logic [EDGE_W-1:0]         edge_clamped;
    logic [HB_W-1:0]           hist_base_full;
    logic [SLOT_W:0]           slot_inc;
    logic [SLOT_W-1:0]         slot_wrap;
    logic [SLOT_W:0]           head_plus_n;
    logic [SLOT_W:0]           head_inc;
    logic [SLOT_W-1:0]         put_slot;
    logic [CNT_W-1:0]          meta_cnt;
    logic [SLOT_W-1:0]         meta_head;
    logic [TACC_W-1:0]         tsum_full;

    logic                      ch_re;
    logic [ADC_BITS-1:0]       ch_rdata;
    logic                      meta_re;
    logic                      meta_we;
    logic [META_W-1:0]         meta_wdata;
    logic [META_W-1:0]         meta_rdata;
    logic                      hist_re;
    logic                      hist_we;
    logic [HIST_AW-1:0]        hist_raddr;
    logic [HIST_AW-1:0]        hist_waddr;
    logic [PATCH_SUM_W-1:0]    hist_rdata;

    assign busy          = (state_reg != IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign patch_sum     = patch_sum_reg;
    assign time_sum      = time_sum_reg;
    assign evicted_sum   = evicted_sum_reg;
    assign evicted_valid = evicted_valid_reg;

    always_comb
    begin
        accept     = start && !busy;
        store_addr = CH_AW'({2'b00, channel_index});
        store_ok   = accept && (command == CMD_STORE)
                     && ({2'b00, channel_index} < 9'(NUM_CHANNELS));
        count_lim  = module_size_reg ? 9'(THIRD_COUNT) : 9'(FULL_COUNT);
        eval_ok    = ({2'b00, patch_index} < count_lim)
                     && ({2'b00, patch_index} < 9'(NUM_PATCHES));

        edge_clamped   = (patch_edge_reg > EDGE_W'(MAX_EDGE)) ? EDGE_W'(MAX_EDGE)
                                                              : patch_edge_reg;
        hist_base_full = HB_W'(patch_reg) * HB_W'(WINDOW_DEPTH);
        patch_addr     = patch_reg[PATCH_AW-1:0];

        // cell walk: one adder, +/-1 along k, +/-stride from the row start at row end
        k_last     = ({1'b0, k_reg} == (edge_reg - EDGE_W'(1)));
        l_last     = ({1'b0, l_reg} == (edge_reg - EDGE_W'(1)));
        step_base  = k_last ? row_reg : cell_reg;
        step_delta = k_last ? (module_size_reg ? CELL_W'(THIRD_STRIDE) : CELL_W'(FULL_STRIDE))
                            : CELL_W'(1);
        step_next  = side_select_reg ? (step_base - step_delta) : (step_base + step_delta);

        cell_in_grid = !cell_reg[CELL_W-1] && ($unsigned(cell_reg) < CELL_W'(NUM_CHANNELS));
        cell_addr    = cell_reg[CH_AW-1:0];

        slot_inc  = {1'b0, slot_reg} + (SLOT_W+1)'(1);
        slot_wrap = (slot_inc >= (SLOT_W+1)'(WINDOW_DEPTH))
                    ? SLOT_W'(slot_inc - (SLOT_W+1)'(WINDOW_DEPTH)) : SLOT_W'(slot_inc);

        head_plus_n = (SLOT_W+1)'(head_reg) + (SLOT_W+1)'(n_reg);
        head_inc    = (SLOT_W+1)'(head_reg) + (SLOT_W+1)'(1);
        if (full_reg)
        begin
            put_slot = head_reg;
        end
        else if (head_plus_n >= (SLOT_W+1)'(WINDOW_DEPTH))
        begin
            put_slot = SLOT_W'(head_plus_n - (SLOT_W+1)'(WINDOW_DEPTH));
        end
        else
        begin
            put_slot = SLOT_W'(head_plus_n);
        end

        meta_cnt  = meta_rdata[META_W-1:SLOT_W];
        meta_head = meta_rdata[SLOT_W-1:0];

        tsum_full = tacc_reg + TACC_W'(psum_reg);

        ch_re      = (state_reg == CELLS);
        meta_re    = (state_reg == SEED);
        hist_re    = (state_reg == HREAD);
        hist_raddr = hist_base_reg + HIST_AW'(slot_reg);
        hist_we    = (state_reg == FINISH);
        hist_waddr = hist_base_reg + HIST_AW'(put_slot);
        meta_we    = (state_reg == FINISH);
        if (full_reg)
        begin
            meta_wdata = {n_reg, ((head_inc >= (SLOT_W+1)'(WINDOW_DEPTH))
                                  ? SLOT_W'(0) : SLOT_W'(head_inc))};
        end
        else
        begin
            meta_wdata = {n_reg + CNT_W'(1), head_reg};
        end
    end

    tpws_ram #(.WIDTH(ADC_BITS), .DEPTH(NUM_CHANNELS)) u_channel_ram
    (
        .clk   (clk),
        .we    (store_ok),
        .waddr (store_addr),
        .wdata (adc_value),
        .re    (ch_re),
        .raddr (cell_addr),
        .rdata (ch_rdata)
    );

    tpws_ram #(.WIDTH(META_W), .DEPTH(NUM_PATCHES)) u_meta_ram
    (
        .clk   (clk),
        .we    (meta_we),
        .waddr (patch_addr),
        .wdata (meta_wdata),
        .re    (meta_re),
        .raddr (patch_addr),
        .rdata (meta_rdata)
    );

    tpws_ram #(.WIDTH(PATCH_SUM_W), .DEPTH(HIST_DEPTH)) u_hist_ram
    (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (psum_reg),
        .re    (hist_re),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= IDLE;
            side_select_reg   <= 1'b0;
            module_size_reg   <= 1'b0;
            patch_edge_reg    <= EDGE_RESET;
            rd_ok_reg         <= 1'b0;
            hv_reg            <= 1'b0;
            hfirst_reg        <= 1'b0;
            done_reg          <= 1'b0;
            status_reg        <= 1'b0;
            patch_sum_reg     <= '0;
            time_sum_reg      <= '0;
            evicted_sum_reg   <= '0;
            evicted_valid_reg <= 1'b0;
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                ch_valid_reg[c] <= 1'b0;
            end
            for (int p = 0; p < NUM_PATCHES; p++)
            begin
                meta_valid_reg[p] <= 1'b0;
            end
        end
        else
        begin
            done_reg   <= 1'b0;
            rd_ok_reg  <= 1'b0;
            hv_reg     <= 1'b0;
            hfirst_reg <= 1'b0;

            if (write_enable)
            begin
                unique case (write_index)
                    REG_SIDE_SELECT: side_select_reg <= write_data[0];
                    REG_MODULE_SIZE: module_size_reg <= write_data[0];
                    REG_PATCH_EDGE:  patch_edge_reg  <= write_data;
                    default:         ;
                endcase
            end

            if (store_ok)
            begin
                ch_valid_reg[store_addr] <= 1'b1;
            end

            // pipelined read data lands in the cycle after the address
            if (rd_ok_reg)
            begin
                pacc_reg <= pacc_reg + PACC_W'(ch_rdata);
            end
            if (hv_reg)
            begin
                if (hfirst_reg)
                begin
                    evicted_reg <= hist_rdata;
                end
                else
                begin
                    tacc_reg <= tacc_reg + TACC_W'(hist_rdata);
                end
            end

            unique case (state_reg)
                IDLE:
                begin
                    if (accept && (command == CMD_EVAL))
                    begin
                        if (eval_ok)
                        begin
                            patch_reg <= patch_index;
                            state_reg <= SEED;
                        end
                        else
                        begin
                            done_reg          <= 1'b1;
                            status_reg        <= 1'b1;
                            patch_sum_reg     <= '0;
                            time_sum_reg      <= '0;
                            evicted_sum_reg   <= '0;
                            evicted_valid_reg <= 1'b0;
                        end
                    end
                end
                SEED:
                begin
                    cell_reg      <= seed_of(patch_reg, module_size_reg, side_select_reg);
                    row_reg       <= seed_of(patch_reg, module_size_reg, side_select_reg);
                    edge_reg      <= edge_clamped;
                    k_reg         <= 2'd0;
                    l_reg         <= 2'd0;
                    pacc_reg      <= '0;
                    tacc_reg      <= '0;
                    evicted_reg   <= '0;
                    hist_base_reg <= HIST_AW'(hist_base_full);
                    state_reg     <= (edge_clamped == EDGE_W'(0)) ? CDRAIN : CELLS;
                end
                CELLS:
                begin
                    rd_ok_reg <= cell_in_grid && ch_valid_reg[cell_addr];
                    cell_reg  <= step_next;
                    if (k_last)
                    begin
                        k_reg   <= 2'd0;
                        l_reg   <= l_reg + 2'd1;
                        row_reg <= step_next;
                        if (l_last)
                        begin
                            state_reg <= CDRAIN;
                        end
                    end
                    else
                    begin
                        k_reg <= k_reg + 2'd1;
                    end
                end
                CDRAIN:
                begin
                    state_reg <= META;
                end
                META:
                begin
                    psum_reg <= (pacc_reg > PACC_W'(PATCH_SUM_MAX)) ? PATCH_SUM_MAX
                                                                    : pacc_reg[PATCH_SUM_W-1:0];
                    i_reg    <= '0;
                    if (meta_valid_reg[patch_addr])
                    begin
                        n_reg     <= meta_cnt;
                        head_reg  <= meta_head;
                        slot_reg  <= meta_head;
                        full_reg  <= (meta_cnt == CNT_W'(WINDOW_DEPTH));
                        state_reg <= (meta_cnt == '0) ? FINISH : HREAD;
                    end
                    else
                    begin
                        n_reg     <= '0;
                        head_reg  <= '0;
                        slot_reg  <= '0;
                        full_reg  <= 1'b0;
                        state_reg <= FINISH;
                    end
                end
                HREAD:
                begin
                    hv_reg     <= 1'b1;
                    hfirst_reg <= full_reg && (i_reg == '0);
                    slot_reg   <= slot_wrap;
                    i_reg      <= i_reg + CNT_W'(1);
                    if (i_reg == (n_reg - CNT_W'(1)))
                    begin
                        state_reg <= HDRAIN;
                    end
                end
                HDRAIN:
                begin
                    state_reg <= FINISH;
                end
                FINISH:
                begin
                    meta_valid_reg[patch_addr] <= 1'b1;
                    done_reg          <= 1'b1;
                    status_reg        <= 1'b0;
                    patch_sum_reg     <= psum_reg;
                    time_sum_reg      <= (tsum_full > TACC_W'(TIME_SUM_MAX))
                                         ? TIME_SUM_MAX : tsum_full[TIME_SUM_W-1:0];
                    evicted_sum_reg   <= evicted_reg;
                    evicted_valid_reg <= full_reg;
                    state_reg         <= IDLE;
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    // results only appear once the sequencer has returned to idle
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobed while busy");

    a_store_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (command == CMD_STORE)) |=> !busy)
        else $error("store word made the unit busy");

    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (command == CMD_EVAL) && eval_ok) |=> (busy && !done))
        else $error("in-range evaluate did not start the sequencer");

    a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> ((patch_sum == '0) && (time_sum == '0) && !evicted_valid))
        else $error("out-of-range result carries data");

    a_evict_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !evicted_valid) |-> (evicted_sum == '0))
        else $error("evicted sum without eviction");

endmodule
